FILE: rtl/pedc_pkg.sv
// ----------------------------------------------------------------------------
// Pointer edge diff classifier package
// Shared constants, codes and types for the classifier front, queue and back.
// ----------------------------------------------------------------------------
package pedc_pkg;

   localparam int SAMPLE_DEPTH_DEFAULT = 24;
   localparam int QUEUE_DEPTH          = 4;
   localparam int CSR_ADDR_W           = 5;
   localparam int CSR_DATA_W           = 64;

   localparam logic [32:0] MODULE_SPAN = 33'd16777216;
   localparam logic [63:0] LOW_LIMIT   = 64'h0000_0000_0001_0000;
   localparam logic [63:0] HIGH_LIMIT  = 64'h0000_8000_0000_0000;
   localparam logic [63:0] ALIGN_MASK  = 64'h0000_0000_0000_0007;
   localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      REG_ENABLE      = 2'd0,
      REG_MODULE_BASE = 2'd1,
      REG_ARENA_BASE  = 2'd2,
      REG_ARENA_LIMIT = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_COMPARE = 2'd1,
      OP_READ    = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      CLS_SAME       = 3'd0,
      CLS_PLAIN      = 3'd1,
      CLS_NULL       = 3'd2,
      CLS_POISON     = 3'd3,
      CLS_OTHER      = 3'd4,
      CLS_INTRODUCED = 3'd5
   } class_type;

   typedef struct packed {
      logic        enable;
      logic [46:0] module_base;
      logic [47:0] module_end;
      logic [46:0] arena_base;
      logic [46:0] arena_limit;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      logic [47:0] word_address;
      logic [63:0] pre_word;
      logic [63:0] post_word;
      logic        page_start;
      logic [4:0]  sample_index;
   } item_type;

   typedef struct packed {
      item_type item;
      logic     changed;
      logic     pre_ext;
      logic     post_ext;
      logic     post_zero;
      logic     post_ones;
   } work_type;

endpackage

FILE: rtl/pedc_csr.sv
// ----------------------------------------------------------------------------
// Pointer edge diff classifier register file
// Holds the detector enable, module window and arena range registers.
// ----------------------------------------------------------------------------
module pedc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pedc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [pedc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [pedc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output pedc_pkg::cfg_type                   cfg
);

   logic                    wr;
   pedc_pkg::reg_index_type index;
   logic                    enable_ff, enable_in;
   logic [46:0]             module_base_ff, module_base_in;
   logic [47:0]             module_end_ff, module_end_in;
   logic [46:0]             arena_base_ff, arena_base_in;
   logic [46:0]             arena_limit_ff, arena_limit_in;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign index  = pedc_pkg::reg_index_type'(paddr[4:3]);

   always_comb begin
      enable_in      = enable_ff;
      module_base_in = module_base_ff;
      module_end_in  = module_end_ff;
      arena_base_in  = arena_base_ff;
      arena_limit_in = arena_limit_ff;
      if (wr) begin
         case (index)
            pedc_pkg::REG_ENABLE: begin
               enable_in = pwdata[0];
            end
            pedc_pkg::REG_MODULE_BASE: begin
               module_base_in = pwdata[46:0];
               module_end_in  = 48'(pwdata[46:0]) + 48'(pedc_pkg::MODULE_SPAN);
            end
            pedc_pkg::REG_ARENA_BASE: begin
               arena_base_in = pwdata[46:0];
            end
            pedc_pkg::REG_ARENA_LIMIT: begin
               arena_limit_in = pwdata[46:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b1;
         module_base_ff <= '0;
         module_end_ff  <= 48'(pedc_pkg::MODULE_SPAN);
         arena_base_ff  <= '0;
         arena_limit_ff <= '0;
      end else begin
         enable_ff      <= enable_in;
         module_base_ff <= module_base_in;
         module_end_ff  <= module_end_in;
         arena_base_ff  <= arena_base_in;
         arena_limit_ff <= arena_limit_in;
      end
   end

   always_comb begin
      case (index)
         pedc_pkg::REG_ENABLE:      prdata = 64'(enable_ff);
         pedc_pkg::REG_MODULE_BASE: prdata = 64'(module_base_ff);
         pedc_pkg::REG_ARENA_BASE:  prdata = 64'(arena_base_ff);
         pedc_pkg::REG_ARENA_LIMIT: prdata = 64'(arena_limit_ff);
         default:                   prdata = '0;
      endcase
   end

   assign cfg.enable      = enable_ff;
   assign cfg.module_base = module_base_ff;
   assign cfg.module_end  = module_end_ff;
   assign cfg.arena_base  = arena_base_ff;
   assign cfg.arena_limit = arena_limit_ff;

endmodule

FILE: rtl/pedc_front.sv
// ----------------------------------------------------------------------------
// Pointer edge diff classifier front
// Registers each accepted word and tests both values for external pointers.
// ----------------------------------------------------------------------------
module pedc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  pedc_pkg::item_type  item,
   input  pedc_pkg::cfg_type   cfg,
   output logic                work_push,
   input  logic                work_full,
   output pedc_pkg::work_type  work
);

   logic               valid_ff, valid_in;
   pedc_pkg::item_type item_ff;
   logic               accept;
   logic               move;

   function automatic logic looks_external(logic [63:0] v, pedc_pkg::cfg_type c);
      logic in_span;
      logic in_arena;
      logic in_module;
      in_span   = (v >= pedc_pkg::LOW_LIMIT) && (v < pedc_pkg::HIGH_LIMIT) &&
                  ((v & pedc_pkg::ALIGN_MASK) == '0);
      in_arena  = (v[46:0] >= c.arena_base) && (v[46:0] < c.arena_limit);
      in_module = (c.module_base != '0) && (v[46:0] >= c.module_base) &&
                  ({1'b0, v[46:0]} < c.module_end);
      return in_span && !in_arena && !in_module;
   endfunction

   assign move      = valid_ff && !work_full;
   assign full      = valid_ff && work_full;
   assign accept    = push && !full;
   assign work_push = move;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (move) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item;
      end
   end

   always_comb begin
      work.item      = item_ff;
      work.changed   = item_ff.pre_word != item_ff.post_word;
      work.pre_ext   = looks_external(item_ff.pre_word, cfg);
      work.post_ext  = looks_external(item_ff.post_word, cfg);
      work.post_zero = item_ff.post_word == '0;
      work.post_ones = item_ff.post_word == pedc_pkg::ALL_ONES;
   end

endmodule

FILE: rtl/pedc_queue.sv
// ----------------------------------------------------------------------------
// Pointer edge diff classifier work queue
// Short first-in first-out queue of tested words between front and back.
// ----------------------------------------------------------------------------
module pedc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  pedc_pkg::work_type  wr_data,
   output logic                q_full,
   input  logic                rd_en,
   output pedc_pkg::work_type  rd_data,
   output logic                q_empty
);

   localparam int PTR_W = $clog2(pedc_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(pedc_pkg::QUEUE_DEPTH + 1);

   pedc_pkg::work_type entry_ff [pedc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr;
   logic               do_rd;

   assign q_full  = count_ff == CNT_W'(pedc_pkg::QUEUE_DEPTH);
   assign q_empty = count_ff == '0;
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(pedc_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(pedc_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/pedc_back.sv
// ----------------------------------------------------------------------------
// Pointer edge diff classifier back
// Carries out clear, compare and sample read, keeps tallies and sample store.
// ----------------------------------------------------------------------------
module pedc_back #(
   parameter int SAMPLE_DEPTH = pedc_pkg::SAMPLE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  pedc_pkg::work_type  work,
   input  logic                work_empty,
   output logic                work_pop,
   input  logic                pop,
   output logic                empty,
   output logic [2:0]          word_class,
   output logic [31:0]         changed_count,
   output logic [31:0]         null_count,
   output logic [31:0]         poison_count,
   output logic [31:0]         other_count,
   output logic [31:0]         introduced_count,
   output logic [31:0]         page_count,
   output logic [4:0]          samples_held,
   output logic [47:0]         sample_address,
   output logic [63:0]         sample_pre,
   output logic [63:0]         sample_post
);

   localparam int IDX_W  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
   localparam int FILL_W = $clog2(SAMPLE_DEPTH + 1);
   localparam int CMP_W  = (FILL_W > 5) ? FILL_W : 5;

   logic [47:0] addr_mem [SAMPLE_DEPTH];
   logic [63:0] pre_mem  [SAMPLE_DEPTH];
   logic [63:0] post_mem [SAMPLE_DEPTH];

   logic                 issue;
   logic                 res_valid_ff, res_valid_in;
   pedc_pkg::class_type  res_class_ff, res_class_in;
   logic                 hit_ff, hit_in;
   logic [31:0]          changed_ff, changed_in;
   logic [31:0]          null_ff, null_in;
   logic [31:0]          poison_ff, poison_in;
   logic [31:0]          other_ff, other_in;
   logic [31:0]          introduced_ff, introduced_in;
   logic [31:0]          page_ff, page_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic                 store_wr;
   logic                 room;
   logic [47:0]          rd_addr_ff;
   logic [63:0]          rd_pre_ff;
   logic [63:0]          rd_post_ff;

   function automatic logic [31:0] tally_bump(logic [31:0] t);
      return (t == '1) ? t : t + 32'd1;
   endfunction

   assign issue    = !work_empty && (!res_valid_ff || pop);
   assign work_pop = issue;
   assign room     = fill_ff < FILL_W'(SAMPLE_DEPTH);

   always_comb begin
      changed_in    = changed_ff;
      null_in       = null_ff;
      poison_in     = poison_ff;
      other_in      = other_ff;
      introduced_in = introduced_ff;
      page_in       = page_ff;
      fill_in       = fill_ff;
      res_class_in  = pedc_pkg::CLS_SAME;
      hit_in        = 1'b0;
      store_wr      = 1'b0;
      res_valid_in  = res_valid_ff;
      if (pop && res_valid_ff) begin
         res_valid_in = 1'b0;
      end
      if (issue) begin
         res_valid_in = 1'b1;
         case (work.item.op)
            pedc_pkg::OP_CLEAR: begin
               if (enable) begin
                  changed_in    = '0;
                  null_in       = '0;
                  poison_in     = '0;
                  other_in      = '0;
                  introduced_in = '0;
                  page_in       = '0;
                  fill_in       = '0;
               end
            end
            pedc_pkg::OP_COMPARE: begin
               if (enable) begin
                  if (work.item.page_start) begin
                     page_in = tally_bump(page_ff);
                  end
                  if (work.changed) begin
                     changed_in   = tally_bump(changed_ff);
                     res_class_in = pedc_pkg::CLS_PLAIN;
                     if (work.pre_ext) begin
                        if (work.post_zero) begin
                           null_in      = tally_bump(null_ff);
                           res_class_in = pedc_pkg::CLS_NULL;
                        end else if (work.post_ones) begin
                           poison_in    = tally_bump(poison_ff);
                           res_class_in = pedc_pkg::CLS_POISON;
                        end else begin
                           other_in     = tally_bump(other_ff);
                           res_class_in = pedc_pkg::CLS_OTHER;
                        end
                     end else if (work.post_ext) begin
                        introduced_in = tally_bump(introduced_ff);
                        res_class_in  = pedc_pkg::CLS_INTRODUCED;
                     end
                     if ((work.pre_ext || work.post_ext) && room) begin
                        store_wr = 1'b1;
                        fill_in  = fill_ff + 1'b1;
                     end
                  end
               end
            end
            pedc_pkg::OP_READ: begin
               hit_in = CMP_W'(work.item.sample_index) < CMP_W'(fill_ff);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff  <= 1'b0;
         changed_ff    <= '0;
         null_ff       <= '0;
         poison_ff     <= '0;
         other_ff      <= '0;
         introduced_ff <= '0;
         page_ff       <= '0;
         fill_ff       <= '0;
      end else begin
         res_valid_ff  <= res_valid_in;
         changed_ff    <= changed_in;
         null_ff       <= null_in;
         poison_ff     <= poison_in;
         other_ff      <= other_in;
         introduced_ff <= introduced_in;
         page_ff       <= page_in;
         fill_ff       <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         res_class_ff <= res_class_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         addr_mem[fill_ff[IDX_W-1:0]] <= work.item.word_address;
         pre_mem[fill_ff[IDX_W-1:0]]  <= work.item.pre_word;
         post_mem[fill_ff[IDX_W-1:0]] <= work.item.post_word;
      end
   end

   always_ff @(posedge clock) begin
      if (hit_in) begin
         rd_addr_ff <= addr_mem[IDX_W'(work.item.sample_index)];
         rd_pre_ff  <= pre_mem[IDX_W'(work.item.sample_index)];
         rd_post_ff <= post_mem[IDX_W'(work.item.sample_index)];
      end
   end

   assign empty            = !res_valid_ff;
   assign word_class       = res_class_ff;
   assign changed_count    = changed_ff;
   assign null_count       = null_ff;
   assign poison_count     = poison_ff;
   assign other_count      = other_ff;
   assign introduced_count = introduced_ff;
   assign page_count       = page_ff;
   assign samples_held     = 5'(fill_ff);
   assign sample_address   = hit_ff ? rd_addr_ff : '0;
   assign sample_pre       = hit_ff ? rd_pre_ff : '0;
   assign sample_post      = hit_ff ? rd_post_ff : '0;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(SAMPLE_DEPTH))
      else $error("Sample fill exceeds the store depth.");

   a_store_advances: assert property (@(posedge clock) disable iff (reset)
      store_wr |=> fill_ff == FILL_W'($past(fill_ff) + 1'b1))
      else $error("Sample store write did not advance the fill.");

   a_tallies_idle: assert property (@(posedge clock) disable iff (reset)
      !issue |=> $stable(changed_ff) && $stable(page_ff) && $stable(fill_ff))
      else $error("Tallies changed without an issued word.");

   a_break_counted: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && res_class_ff != pedc_pkg::CLS_SAME |-> changed_ff != '0)
      else $error("Changed word reported with a zero change tally.");

   a_hit_needs_fill: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && hit_ff |-> fill_ff != '0)
      else $error("Sample read hit with an empty store.");

endmodule

FILE: rtl/pointer_edge_diff_classifier.sv
// ----------------------------------------------------------------------------
// Pointer edge diff classifier
// Classifies changed snapshot words by external pointer content and keeps
// saturating tallies and a store of the first breaks found.
//
//   Channel   Handshake            Contents
//   request   push / full          req_op, address, before and after words
//   response  empty / pop          rsp_word_class, tallies, sample read data
//   config    psel/penable/pready  enable, module base, arena base and limit
//
// One word is taken every cycle while full is low; an accepted word passes
// through the front register and the work queue into the result register.
// The front register, a four-entry work queue and the result register let
// both sides stall on their own; full rises when the front word waits on a full queue.
// Reset is synchronous and clears tallies, the sample fill and all queues.
// The sample store needs no clearing pass; only filled entries are read.
// ----------------------------------------------------------------------------
module pointer_edge_diff_classifier #(
   parameter int SAMPLE_DEPTH = pedc_pkg::SAMPLE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [1:0]                       req_op,
   input  logic [47:0]                      req_word_address,
   input  logic [63:0]                      req_pre_word,
   input  logic [63:0]                      req_post_word,
   input  logic                             req_page_start,
   input  logic [4:0]                       req_sample_index,
   output logic                             empty,
   input  logic                             pop,
   output logic [2:0]                       rsp_word_class,
   output logic [31:0]                      rsp_changed_count,
   output logic [31:0]                      rsp_null_count,
   output logic [31:0]                      rsp_poison_count,
   output logic [31:0]                      rsp_other_count,
   output logic [31:0]                      rsp_introduced_count,
   output logic [31:0]                      rsp_page_count,
   output logic [4:0]                       rsp_samples_held,
   output logic [47:0]                      rsp_sample_address,
   output logic [63:0]                      rsp_sample_pre,
   output logic [63:0]                      rsp_sample_post,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pedc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [pedc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [pedc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   pedc_pkg::cfg_type  cfg;
   pedc_pkg::item_type item;
   pedc_pkg::work_type front_work;
   pedc_pkg::work_type queue_work;
   logic               work_push;
   logic               work_full;
   logic               work_pop;
   logic               work_empty;

   assign item.op           = pedc_pkg::op_type'(req_op);
   assign item.word_address = req_word_address;
   assign item.pre_word     = req_pre_word;
   assign item.post_word    = req_post_word;
   assign item.page_start   = req_page_start;
   assign item.sample_index = req_sample_index;

   pedc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pedc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .item      (item),
      .cfg       (cfg),
      .work_push (work_push),
      .work_full (work_full),
      .work      (front_work)
   );

   pedc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (work_push),
      .wr_data (front_work),
      .q_full  (work_full),
      .rd_en   (work_pop),
      .rd_data (queue_work),
      .q_empty (work_empty)
   );

   pedc_back #(
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .enable           (cfg.enable),
      .work             (queue_work),
      .work_empty       (work_empty),
      .work_pop         (work_pop),
      .pop              (pop),
      .empty            (empty),
      .word_class       (rsp_word_class),
      .changed_count    (rsp_changed_count),
      .null_count       (rsp_null_count),
      .poison_count     (rsp_poison_count),
      .other_count      (rsp_other_count),
      .introduced_count (rsp_introduced_count),
      .page_count       (rsp_page_count),
      .samples_held     (rsp_samples_held),
      .sample_address   (rsp_sample_address),
      .sample_pre       (rsp_sample_pre),
      .sample_post      (rsp_sample_post)
   );

endmodule

FILE: tb/pointer_edge_diff_classifier_tb.sv
// ----------------------------------------------------------------------------
// Pointer edge diff classifier testbench
// Streams compare, clear, sample read and unused-op words through the
// classifier under several register settings and idling patterns. A
// scoreboard predicts each result word from its own copy of the tallies,
// sample store and registers, and checks every field of every result.
// ----------------------------------------------------------------------------
module pointer_edge_diff_classifier_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CYCLE_LIMIT = 200000;
   localparam int          STORE_DEPTH = pedc_pkg::SAMPLE_DEPTH_DEFAULT;
   localparam logic [1:0]  OP_UNUSED   = 2'd3;
   localparam logic [46:0] ADDR47_MAX  = '1;

   localparam int T_CHANGED    = 0;
   localparam int T_NULL       = 1;
   localparam int T_POISON     = 2;
   localparam int T_OTHER      = 3;
   localparam int T_INTRODUCED = 4;
   localparam int T_PAGE       = 5;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [47:0] word_address;
      logic [63:0] pre_word;
      logic [63:0] post_word;
      logic        page_start;
      logic [4:0]  sample_index;
   } req_word_type;

   typedef struct packed {
      pedc_pkg::class_type cls;
      logic [5:0][31:0]    cnt;
      logic [4:0]          held;
      logic [47:0]         s_addr;
      logic [63:0]         s_pre;
      logic [63:0]         s_post;
   } verdict_type;

   class diff_scoreboard;
      bit               detect_on;
      logic [46:0]      mod_base;
      logic [46:0]      arn_base;
      logic [46:0]      arn_limit;
      logic [5:0][31:0] tally;
      int unsigned      fill;
      logic [47:0]      keep_addr [STORE_DEPTH];
      logic [63:0]      keep_pre [STORE_DEPTH];
      logic [63:0]      keep_post [STORE_DEPTH];
      verdict_type      expected_q [$];
      int               errors;
      string            tally_names [6] = '{"changed_count", "null_count", "poison_count",
                                            "other_count", "introduced_count", "page_count"};

      function new();
         detect_on = 1'b1;
         mod_base  = '0;
         arn_base  = '0;
         arn_limit = '0;
         tally     = '0;
         fill      = 0;
         errors    = 0;
      endfunction

      function void set_reg(pedc_pkg::reg_index_type idx, logic [63:0] value);
         case (idx)
            pedc_pkg::REG_ENABLE:      detect_on = value[0];
            pedc_pkg::REG_MODULE_BASE: mod_base  = value[46:0];
            pedc_pkg::REG_ARENA_BASE:  arn_base  = value[46:0];
            pedc_pkg::REG_ARENA_LIMIT: arn_limit = value[46:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void count_up(int k);
         if (tally[k] != '1) tally[k] = tally[k] + 32'd1;
      endfunction

      function bit is_ext_ptr(logic [63:0] v);
         logic [63:0] mod_end;
         mod_end = 64'(mod_base) + 64'(pedc_pkg::MODULE_SPAN);
         if (v < pedc_pkg::LOW_LIMIT || v >= pedc_pkg::HIGH_LIMIT ||
             (v & pedc_pkg::ALIGN_MASK) != 0) return 1'b0;
         if (v >= 64'(arn_base) && v < 64'(arn_limit)) return 1'b0;
         if (mod_base != 0 && v >= 64'(mod_base) && v < mod_end) return 1'b0;
         return 1'b1;
      endfunction

      function pedc_pkg::class_type classify(req_word_type w);
         pedc_pkg::class_type c;
         bit                  pe;
         bit                  qe;
         if (w.page_start) count_up(T_PAGE);
         if (w.pre_word == w.post_word) return pedc_pkg::CLS_SAME;
         count_up(T_CHANGED);
         pe = is_ext_ptr(w.pre_word);
         qe = is_ext_ptr(w.post_word);
         if (!pe && !qe) return pedc_pkg::CLS_PLAIN;
         if (pe) begin
            if (w.post_word == 64'd0) begin
               count_up(T_NULL);
               c = pedc_pkg::CLS_NULL;
            end else if (w.post_word == pedc_pkg::ALL_ONES) begin
               count_up(T_POISON);
               c = pedc_pkg::CLS_POISON;
            end else begin
               count_up(T_OTHER);
               c = pedc_pkg::CLS_OTHER;
            end
         end else begin
            count_up(T_INTRODUCED);
            c = pedc_pkg::CLS_INTRODUCED;
         end
         if (fill < STORE_DEPTH) begin
            keep_addr[fill] = w.word_address;
            keep_pre[fill]  = w.pre_word;
            keep_post[fill] = w.post_word;
            fill++;
         end
         return c;
      endfunction

      function void note_word(req_word_type w);
         verdict_type v;
         v     = '0;
         v.cls = pedc_pkg::CLS_SAME;
         case (w.op)
            pedc_pkg::OP_CLEAR: begin
               if (detect_on) begin
                  tally = '0;
                  fill  = 0;
               end
            end
            pedc_pkg::OP_COMPARE: begin
               if (detect_on) v.cls = classify(w);
            end
            pedc_pkg::OP_READ: begin
               if (w.sample_index < fill) begin
                  v.s_addr = keep_addr[w.sample_index];
                  v.s_pre  = keep_pre[w.sample_index];
                  v.s_post = keep_post[w.sample_index];
               end
            end
            default: ;
         endcase
         v.cnt  = tally;
         v.held = 5'(fill);
         expected_q.push_back(v);
      endfunction

      function void report(string field, logic [63:0] want, logic [63:0] got);
         $error("%s: expected %0h, actual %0h", field, want, got);
         errors++;
      endfunction

      function void check_result(verdict_type got);
         verdict_type want;
         if (expected_q.size() == 0) begin
            $error("result word arrived with no expectation waiting");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.cls !== want.cls) report("word_class", want.cls, got.cls);
         for (int k = 0; k < 6; k++) begin
            if (got.cnt[k] !== want.cnt[k]) report(tally_names[k], want.cnt[k], got.cnt[k]);
         end
         if (got.held !== want.held) report("samples_held", want.held, got.held);
         if (got.s_addr !== want.s_addr) report("sample_address", want.s_addr, got.s_addr);
         if (got.s_pre !== want.s_pre) report("sample_pre", want.s_pre, got.s_pre);
         if (got.s_post !== want.s_post) report("sample_post", want.s_post, got.s_post);
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            push;
   logic                            full;
   logic [1:0]                      req_op;
   logic [47:0]                     req_word_address;
   logic [63:0]                     req_pre_word;
   logic [63:0]                     req_post_word;
   logic                            req_page_start;
   logic [4:0]                      req_sample_index;
   logic                            empty;
   logic                            pop;
   logic [2:0]                      rsp_word_class;
   logic [31:0]                     rsp_changed_count;
   logic [31:0]                     rsp_null_count;
   logic [31:0]                     rsp_poison_count;
   logic [31:0]                     rsp_other_count;
   logic [31:0]                     rsp_introduced_count;
   logic [31:0]                     rsp_page_count;
   logic [4:0]                      rsp_samples_held;
   logic [47:0]                     rsp_sample_address;
   logic [63:0]                     rsp_sample_pre;
   logic [63:0]                     rsp_sample_post;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [pedc_pkg::CSR_ADDR_W-1:0] paddr;
   logic [pedc_pkg::CSR_DATA_W-1:0] pwdata;
   logic [pedc_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   diff_scoreboard board;
   int             send_idle_pct;
   int             recv_stall_pct;
   int unsigned    cycle_count;

   pointer_edge_diff_classifier #(
      .SAMPLE_DEPTH(STORE_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_op(req_op),
      .req_word_address(req_word_address),
      .req_pre_word(req_pre_word),
      .req_post_word(req_post_word),
      .req_page_start(req_page_start),
      .req_sample_index(req_sample_index),
      .empty(empty),
      .pop(pop),
      .rsp_word_class(rsp_word_class),
      .rsp_changed_count(rsp_changed_count),
      .rsp_null_count(rsp_null_count),
      .rsp_poison_count(rsp_poison_count),
      .rsp_other_count(rsp_other_count),
      .rsp_introduced_count(rsp_introduced_count),
      .rsp_page_count(rsp_page_count),
      .rsp_samples_held(rsp_samples_held),
      .rsp_sample_address(rsp_sample_address),
      .rsp_sample_pre(rsp_sample_pre),
      .rsp_sample_post(rsp_sample_post),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic verdict_type result_now();
      verdict_type v;
      v.cls    = pedc_pkg::class_type'(rsp_word_class);
      v.cnt    = {rsp_page_count, rsp_introduced_count, rsp_other_count,
                  rsp_poison_count, rsp_null_count, rsp_changed_count};
      v.held   = rsp_samples_held;
      v.s_addr = rsp_sample_address;
      v.s_pre  = rsp_sample_pre;
      v.s_post = rsp_sample_post;
      return v;
   endfunction

   initial begin
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) board.check_result(result_now());
         pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   initial begin
      cycle_count = 0;
      do begin
         @(posedge clock);
         cycle_count++;
      end while (cycle_count < CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [46:0] rand47();
      return 47'({$urandom, $urandom});
   endfunction

   function automatic logic [63:0] pick_value();
      logic [63:0] r;
      logic [63:0] span;
      r = ({17'b0, rand47()} & ~pedc_pkg::ALIGN_MASK) | pedc_pkg::LOW_LIMIT;
      case ($urandom_range(0, 15))
         0: r = 64'd0;
         1: r = pedc_pkg::ALL_ONES;
         2: r = {$urandom, $urandom};
         3: r = 64'($urandom_range(0, 16'hFFFF));
         4: r = r | 64'($urandom_range(1, 7));
         5: begin
            span = 64'(board.arn_limit) - 64'(board.arn_base);
            r = 64'(board.arn_base);
            if (board.arn_limit > board.arn_base) r = r + ({$urandom, $urandom} % span);
            r = r & ~pedc_pkg::ALIGN_MASK;
         end
         6: r = (64'(board.mod_base) + 64'($urandom_range(0, 24'hFFFFFF))) &
                ~pedc_pkg::ALIGN_MASK;
         7: begin
            case ($urandom_range(0, 11))
               0: r = pedc_pkg::LOW_LIMIT;
               1: r = pedc_pkg::LOW_LIMIT - 64'd8;
               2: r = pedc_pkg::HIGH_LIMIT - 64'd8;
               3: r = pedc_pkg::HIGH_LIMIT;
               4: r = 64'(board.arn_base);
               5: r = 64'(board.arn_base) - 64'd8;
               6: r = 64'(board.arn_limit) - 64'd8;
               7: r = 64'(board.arn_limit);
               8: r = 64'(board.mod_base);
               9: r = 64'(board.mod_base) - 64'd8;
               10: r = 64'(board.mod_base) + 64'(pedc_pkg::MODULE_SPAN) - 64'd8;
               default: r = 64'(board.mod_base) + 64'(pedc_pkg::MODULE_SPAN);
            endcase
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic push_word(input req_word_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push             <= 1'b1;
      req_op           <= w.op;
      req_word_address <= w.word_address;
      req_pre_word     <= w.pre_word;
      req_post_word    <= w.post_word;
      req_page_start   <= w.page_start;
      req_sample_index <= w.sample_index;
      @(posedge clock);
      while (full) @(posedge clock);
      board.note_word(w);
   endtask

   task automatic drain_results();
      push <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input pedc_pkg::reg_index_type idx, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.set_reg(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic en, input logic [46:0] mb, input logic [46:0] ab,
                            input logic [46:0] al);
      drain_results();
      csr_write(pedc_pkg::REG_ENABLE, 64'(en));
      csr_write(pedc_pkg::REG_MODULE_BASE, 64'(mb));
      csr_write(pedc_pkg::REG_ARENA_BASE, 64'(ab));
      csr_write(pedc_pkg::REG_ARENA_LIMIT, 64'(al));
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_SENDER: begin
            send_idle_pct  = 64;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = 64;
         end
         IDLE_BOTH: begin
            send_idle_pct  = 17;
            recv_stall_pct = 17;
         end
         default: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
      endcase
   endtask

   task automatic send_compare(input logic [47:0] a, input logic [63:0] x,
                               input logic [63:0] y, input logic pg);
      req_word_type w;
      w              = '0;
      w.op           = pedc_pkg::OP_COMPARE;
      w.word_address = a;
      w.pre_word     = x;
      w.post_word    = y;
      w.page_start   = pg;
      push_word(w);
   endtask

   task automatic send_plain_op(input logic [1:0] op, input logic [4:0] idx, input logic pg);
      req_word_type w;
      w              = '0;
      w.op           = op;
      w.sample_index = idx;
      w.page_start   = pg;
      push_word(w);
   endtask

   task automatic run_directed();
      send_plain_op(pedc_pkg::OP_CLEAR, 5'd0, 1'b1);
      send_compare(48'h0, 64'h1234_5678, 64'h1234_5678, 1'b1);
      send_compare(48'h1000, 64'd5, 64'd6, 1'b0);
      send_compare(48'h1008, pedc_pkg::LOW_LIMIT, 64'd0, 1'b1);
      send_compare(48'h1010, pedc_pkg::HIGH_LIMIT - 64'd8, pedc_pkg::ALL_ONES, 1'b0);
      send_compare(48'h1018, 64'h1_2340, 64'h2_2340, 1'b0);
      send_compare(48'h1020, 64'd3, 64'h7FFF_FFFF_FFF8, 1'b0);
      send_compare(48'h1028, 64'h1_0001, 64'd0, 1'b0);
      send_compare(48'h1030, pedc_pkg::HIGH_LIMIT, 64'd0, 1'b0);
      send_compare(48'h1038, pedc_pkg::LOW_LIMIT - 64'd8, 64'd0, 1'b0);
      send_compare(48'hFFFF_FFFF_FFFF, pedc_pkg::ALL_ONES, 64'd0, 1'b1);
      send_plain_op(pedc_pkg::OP_READ, 5'd0, 1'b0);
      send_plain_op(pedc_pkg::OP_READ, 5'd4, 1'b1);
      send_plain_op(pedc_pkg::OP_READ, 5'd23, 1'b0);
      send_plain_op(OP_UNUSED, 5'd0, 1'b1);

      configure(1'b1, 47'h4000_0000, 47'h10_0000, 47'h20_0000);
      send_compare(48'h2000, 64'h10_0000, 64'd0, 1'b0);
      send_compare(48'h2008, 64'h1F_FFF8, 64'd0, 1'b0);
      send_compare(48'h2010, 64'h20_0000, 64'd0, 1'b0);
      send_compare(48'h2018, 64'h4000_0000, 64'd0, 1'b0);
      send_compare(48'h2020, 64'h40FF_FFF8, 64'd0, 1'b0);
      send_compare(48'h2028, 64'h4100_0000, 64'd0, 1'b0);

      configure(1'b1, 47'h0, 47'h20_0000, 47'h10_0000);
      send_compare(48'h3000, 64'h18_0000, 64'd0, 1'b0);

      configure(1'b0, 47'h0, 47'h0, 47'h0);
      send_plain_op(pedc_pkg::OP_CLEAR, 5'd0, 1'b0);
      send_compare(48'h4000, 64'h2_0000, 64'd0, 1'b1);
      send_plain_op(pedc_pkg::OP_READ, 5'd0, 1'b0);
   endtask

   task automatic run_random(input int count);
      req_word_type w;
      int           r;
      for (int n = 0; n < count; n++) begin
         r              = $urandom_range(0, 99);
         w.word_address = 48'({$urandom, $urandom});
         w.pre_word     = pick_value();
         w.post_word    = ($urandom_range(0, 3) == 0) ? w.pre_word : pick_value();
         w.page_start   = 1'($urandom_range(0, 1));
         w.sample_index = 5'($urandom_range(0, 23));
         if (r < 1) w.op = pedc_pkg::OP_CLEAR;
         else if (r < 76) w.op = pedc_pkg::OP_COMPARE;
         else if (r < 95) w.op = pedc_pkg::OP_READ;
         else w.op = OP_UNUSED;
         push_word(w);
      end
   endtask

   initial begin
      logic [46:0] ab;
      reset            <= 1'b1;
      push             <= 1'b0;
      req_op           <= pedc_pkg::OP_CLEAR;
      req_word_address <= '0;
      req_pre_word     <= '0;
      req_post_word    <= '0;
      req_page_start   <= 1'b0;
      req_sample_index <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      board          = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      for (int p = 0; p < 6; p++) begin
         ab = rand47() & 47'h0000_FFFF_FFF8;
         case (p)
            0: configure(1'b1, 47'h0, 47'h0, 47'h0);
            1: configure(1'b1, ab + 47'h1000_0000, ab, ab + 47'($urandom_range(0, 1 << 22)));
            2: configure(1'b1, ADDR47_MAX, 47'h0, ADDR47_MAX);
            3: configure(1'b1, 47'(pedc_pkg::LOW_LIMIT), ADDR47_MAX, 47'h0);
            4: configure(1'b0, rand47(), ab, ab + 47'h10_0000);
            default: configure(1'b1, rand47(), ab, ab + 47'($urandom_range(0, 1 << 24)));
         endcase
         set_idling(idle_mode_type'(p % 4));
         run_random((p == 4) ? 40 : 95);
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
